// ===== src/fius_pkg.sv =====
package fius_pkg;

   // Flash geometry and image limits
   localparam int unsigned PAGE_BYTES      = 2048;
   localparam int unsigned BLOCK_BYTES     = 131072;
   localparam int unsigned MAX_IMAGE_BYTES = 8388608;
   localparam int unsigned MIN_IMAGE_BYTES = 48;
   localparam int unsigned FIRST_BLOCK     = 32;
   localparam int unsigned FIRST_PAGE      = 2048;
   localparam logic [31:0] IMAGE_MAGIC     = 32'h016f2818;

   localparam int unsigned PAGE_SHIFT  = $clog2(PAGE_BYTES);
   localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);

   // Field widths
   localparam int unsigned CMD_W   = 2;
   localparam int unsigned CODE_W  = 3;
   localparam int unsigned CNT_W   = 24;
   localparam int unsigned BLK_W   = 7;
   localparam int unsigned ADDR_W  = 13;
   localparam int unsigned OFF_W   = 23;
   localparam int unsigned NB_W    = 12;

   // Commands
   localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POLL  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // Phases
   localparam logic [CODE_W-1:0] PH_IDLE   = 3'd0;
   localparam logic [CODE_W-1:0] PH_CHECK  = 3'd1;
   localparam logic [CODE_W-1:0] PH_ERASE  = 3'd2;
   localparam logic [CODE_W-1:0] PH_WRITE  = 3'd3;
   localparam logic [CODE_W-1:0] PH_VERIFY = 3'd4;
   localparam logic [CODE_W-1:0] PH_DONE   = 3'd5;
   localparam logic [CODE_W-1:0] PH_FAIL   = 3'd6;

   // Error codes
   localparam logic [CODE_W-1:0] ERR_NONE    = 3'd0;
   localparam logic [CODE_W-1:0] ERR_BLOCK   = 3'd1;
   localparam logic [CODE_W-1:0] ERR_ERASE   = 3'd2;
   localparam logic [CODE_W-1:0] ERR_PROGRAM = 3'd3;
   localparam logic [CODE_W-1:0] ERR_VERIFY  = 3'd4;

   // Flash request codes
   localparam logic [CODE_W-1:0] OP_NONE    = 3'd0;
   localparam logic [CODE_W-1:0] OP_CHECK   = 3'd1;
   localparam logic [CODE_W-1:0] OP_ERASE   = 3'd2;
   localparam logic [CODE_W-1:0] OP_PROGRAM = 3'd3;
   localparam logic [CODE_W-1:0] OP_COMPARE = 3'd4;

   typedef struct packed {
      logic [CODE_W-1:0] phase;
      logic [CODE_W-1:0] error;
      logic [CNT_W-1:0]  cursor;
      logic [CNT_W-1:0]  total;
      logic [CNT_W-1:0]  done;
      logic              changed;
      logic [BLK_W-1:0]  block_count;
   } fius_state_type;

   typedef struct packed {
      logic              accepted;
      logic [CODE_W-1:0] phase;
      logic [CODE_W-1:0] error_code;
      logic [CNT_W-1:0]  done_bytes;
      logic              changed;
      logic [CODE_W-1:0] request_op;
      logic [ADDR_W-1:0] request_address;
      logic [OFF_W-1:0]  request_offset;
      logic [NB_W-1:0]   request_bytes;
   } fius_result_type;

endpackage

// ===== src/fius_step.sv =====
module fius_step (
   input  fius_pkg::fius_state_type    cur,
   input  logic [fius_pkg::CMD_W-1:0]  command,
   input  logic                        image_present,
   input  logic [31:0]                 image_length,
   input  logic [31:0]                 header_magic,
   input  logic [31:0]                 header_size,
   input  logic                        crc_matches,
   input  logic                        op_ok,
   output fius_pkg::fius_state_type    nxt,
   output fius_pkg::fius_result_type   result
);

   // Image bytes left for the page at the cursor, capped at one page
   function automatic logic [fius_pkg::NB_W-1:0] page_amount(
      input logic [fius_pkg::CNT_W-1:0] cursor,
      input logic [fius_pkg::CNT_W-1:0] total
   );
      logic [fius_pkg::CNT_W-1:0] left;
      left = (cursor < total) ? (total - cursor) : '0;
      if (left > fius_pkg::CNT_W'(fius_pkg::PAGE_BYTES)) begin
         return fius_pkg::NB_W'(fius_pkg::PAGE_BYTES);
      end
      return left[fius_pkg::NB_W-1:0];
   endfunction

   logic                       busy;
   logic                       header_ok;
   logic                       accepted;
   logic [fius_pkg::NB_W-1:0]  cur_amount;
   logic [fius_pkg::CNT_W-1:0] blk_next;
   logic [fius_pkg::CNT_W-1:0] byte_next;
   logic [fius_pkg::CNT_W:0]   len_round;

   assign busy = (cur.phase >= fius_pkg::PH_CHECK) && (cur.phase <= fius_pkg::PH_VERIFY);

   assign header_ok = image_present
      && (image_length >= 32'(fius_pkg::MIN_IMAGE_BYTES))
      && (image_length <= 32'(fius_pkg::MAX_IMAGE_BYTES))
      && (header_magic == fius_pkg::IMAGE_MAGIC)
      && (header_size == image_length)
      && crc_matches;

   assign cur_amount = page_amount(cur.cursor, cur.total);
   assign blk_next   = cur.cursor + fius_pkg::CNT_W'(1);
   assign byte_next  = cur.cursor + fius_pkg::CNT_W'(cur_amount);
   assign len_round  = (fius_pkg::CNT_W+1)'(image_length[fius_pkg::CNT_W-1:0])
                     + (fius_pkg::CNT_W+1)'(fius_pkg::BLOCK_BYTES - 1);

   // Advance the sequencer state for one transaction
   always_comb begin
      nxt      = cur;
      accepted = 1'b0;
      case (command)
         fius_pkg::CMD_BEGIN: begin
            if (!busy && header_ok) begin
               nxt.phase       = fius_pkg::PH_CHECK;
               nxt.error       = fius_pkg::ERR_NONE;
               nxt.done        = '0;
               nxt.changed     = 1'b0;
               nxt.total       = image_length[fius_pkg::CNT_W-1:0];
               nxt.cursor      = '0;
               nxt.block_count = fius_pkg::BLK_W'(len_round >> fius_pkg::BLOCK_SHIFT);
               accepted        = 1'b1;
            end
         end
         fius_pkg::CMD_POLL: begin
            case (cur.phase)
               fius_pkg::PH_CHECK: begin
                  if (!op_ok) begin
                     nxt.error = fius_pkg::ERR_BLOCK;
                     nxt.phase = fius_pkg::PH_FAIL;
                  end else if (blk_next == fius_pkg::CNT_W'(cur.block_count)) begin
                     nxt.cursor = '0;
                     nxt.phase  = fius_pkg::PH_ERASE;
                  end else begin
                     nxt.cursor = blk_next;
                  end
               end
               fius_pkg::PH_ERASE: begin
                  // an attempted erase counts as a change even when it fails
                  nxt.changed = 1'b1;
                  if (!op_ok) begin
                     nxt.error = fius_pkg::ERR_ERASE;
                     nxt.phase = fius_pkg::PH_FAIL;
                  end else if (blk_next == fius_pkg::CNT_W'(cur.block_count)) begin
                     nxt.cursor = '0;
                     nxt.done   = '0;
                     nxt.phase  = fius_pkg::PH_WRITE;
                  end else begin
                     nxt.cursor = blk_next;
                  end
               end
               fius_pkg::PH_WRITE: begin
                  if (!op_ok) begin
                     nxt.error = fius_pkg::ERR_PROGRAM;
                     nxt.phase = fius_pkg::PH_FAIL;
                  end else if (byte_next >= cur.total) begin
                     nxt.cursor = '0;
                     nxt.done   = '0;
                     nxt.phase  = fius_pkg::PH_VERIFY;
                  end else begin
                     nxt.cursor = byte_next;
                     nxt.done   = byte_next;
                  end
               end
               fius_pkg::PH_VERIFY: begin
                  if (!op_ok) begin
                     nxt.error = fius_pkg::ERR_VERIFY;
                     nxt.phase = fius_pkg::PH_FAIL;
                  end else begin
                     nxt.cursor = byte_next;
                     nxt.done   = byte_next;
                     if (byte_next >= cur.total) begin
                        nxt.phase = fius_pkg::PH_DONE;
                     end
                  end
               end
               default: ;
            endcase
         end
         fius_pkg::CMD_CLEAR: begin
            if (!busy) begin
               nxt      = '0;
               accepted = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Describe the request pending after this transaction
   always_comb begin
      result.accepted        = accepted;
      result.phase           = nxt.phase;
      result.error_code      = nxt.error;
      result.done_bytes      = nxt.done;
      result.changed         = nxt.changed;
      result.request_op      = fius_pkg::OP_NONE;
      result.request_address = '0;
      result.request_offset  = '0;
      result.request_bytes   = '0;
      case (nxt.phase)
         fius_pkg::PH_CHECK, fius_pkg::PH_ERASE: begin
            result.request_op = (nxt.phase == fius_pkg::PH_CHECK) ?
                                fius_pkg::OP_CHECK : fius_pkg::OP_ERASE;
            result.request_address = fius_pkg::ADDR_W'(fius_pkg::FIRST_BLOCK)
                                   + nxt.cursor[fius_pkg::ADDR_W-1:0];
         end
         fius_pkg::PH_WRITE, fius_pkg::PH_VERIFY: begin
            result.request_op = (nxt.phase == fius_pkg::PH_WRITE) ?
                                fius_pkg::OP_PROGRAM : fius_pkg::OP_COMPARE;
            result.request_address = fius_pkg::ADDR_W'(fius_pkg::FIRST_PAGE)
                                   + fius_pkg::ADDR_W'(nxt.cursor >> fius_pkg::PAGE_SHIFT);
            result.request_offset  = nxt.cursor[fius_pkg::OFF_W-1:0];
            result.request_bytes   = page_amount(nxt.cursor, nxt.total);
         end
         default: ;
      endcase
   end

endmodule

// ===== src/flash_image_update_sequencer.sv =====
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  command, image header fields, op_ok
// rsp      out        rsp_valid / rsp_ready  phase, error, progress, next flash request
//
// After acceptance the transaction sits in the input register, then passes
// through the step logic into the result register.
// One transaction is accepted per cycle while results are taken; the single
// sequencer state register sets that pace.
// Synchronous reset empties both registers and returns the sequencer to idle.
// A stalled result holds the step stage; the input register still takes one
// more transaction while it is empty.
module flash_image_update_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [fius_pkg::CMD_W-1:0]         req_command,
   input  logic                               req_image_present,
   input  logic [31:0]                        req_image_length,
   input  logic [31:0]                        req_header_magic,
   input  logic [31:0]                        req_header_size,
   input  logic                               req_crc_matches,
   input  logic                               req_op_ok,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_accepted,
   output logic [fius_pkg::CODE_W-1:0]        rsp_phase,
   output logic [fius_pkg::CODE_W-1:0]        rsp_error_code,
   output logic [fius_pkg::CNT_W-1:0]         rsp_done_bytes,
   output logic                               rsp_changed,
   output logic [fius_pkg::CODE_W-1:0]        rsp_request_op,
   output logic [fius_pkg::ADDR_W-1:0]        rsp_request_address,
   output logic [fius_pkg::OFF_W-1:0]         rsp_request_offset,
   output logic [fius_pkg::NB_W-1:0]          rsp_request_bytes
);

   logic                          in_valid_ff;
   logic [fius_pkg::CMD_W-1:0]    command_ff;
   logic                          image_present_ff;
   logic [31:0]                   image_length_ff;
   logic [31:0]                   header_magic_ff;
   logic [31:0]                   header_size_ff;
   logic                          crc_matches_ff;
   logic                          op_ok_ff;

   fius_pkg::fius_state_type      state_ff;
   fius_pkg::fius_state_type      state_in;
   fius_pkg::fius_result_type     rsp_ff;
   fius_pkg::fius_result_type     rsp_in;
   logic                          rsp_valid_ff;
   logic                          advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   fius_step u_step (
      .cur           (state_ff),
      .command       (command_ff),
      .image_present (image_present_ff),
      .image_length  (image_length_ff),
      .header_magic  (header_magic_ff),
      .header_size   (header_size_ff),
      .crc_matches   (crc_matches_ff),
      .op_ok         (op_ok_ff),
      .nxt           (state_in),
      .result        (rsp_in)
   );

   // Control: input stage valid, sequencer state, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Capture the incoming transaction
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         command_ff       <= req_command;
         image_present_ff <= req_image_present;
         image_length_ff  <= req_image_length;
         header_magic_ff  <= req_header_magic;
         header_size_ff   <= req_header_size;
         crc_matches_ff   <= req_crc_matches;
         op_ok_ff         <= req_op_ok;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_ff.accepted;
   assign rsp_phase           = rsp_ff.phase;
   assign rsp_error_code      = rsp_ff.error_code;
   assign rsp_done_bytes      = rsp_ff.done_bytes;
   assign rsp_changed         = rsp_ff.changed;
   assign rsp_request_op      = rsp_ff.request_op;
   assign rsp_request_address = rsp_ff.request_address;
   assign rsp_request_offset  = rsp_ff.request_offset;
   assign rsp_request_bytes   = rsp_ff.request_bytes;

endmodule

// ===== src/fius_checker.sv =====
module fius_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic                               rsp_accepted,
   input  logic [fius_pkg::CODE_W-1:0]        rsp_phase,
   input  logic [fius_pkg::CODE_W-1:0]        rsp_error_code,
   input  logic [fius_pkg::CNT_W-1:0]         rsp_done_bytes,
   input  logic [fius_pkg::CODE_W-1:0]        rsp_request_op,
   input  logic [fius_pkg::ADDR_W-1:0]        rsp_request_address
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase)
         && $stable(rsp_request_address) && $stable(rsp_done_bytes))
      else $error("stalled result changed");

   // No flash request outside the busy phases
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phase == fius_pkg::PH_IDLE || rsp_phase == fius_pkg::PH_DONE
         || rsp_phase == fius_pkg::PH_FAIL) |-> rsp_request_op == fius_pkg::OP_NONE)
      else $error("request pending while not busy");

   // A taken begin or clear lands in checking or idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |->
         rsp_phase == fius_pkg::PH_CHECK || rsp_phase == fius_pkg::PH_IDLE)
      else $error("accepted transaction in wrong phase");

   // An error code shows only in the failed phase
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != fius_pkg::ERR_NONE |-> rsp_phase == fius_pkg::PH_FAIL)
      else $error("error code outside failed phase");

   // Reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind flash_image_update_sequencer fius_checker u_fius_checker (.*);

// ===== verif/tb.sv =====
module tb;
   import fius_pkg::*;

   localparam int unsigned HOLD_CYCLES  = 60;
   localparam int unsigned STALL_LIMIT  = 1000;
   localparam int unsigned ITEM_TARGET  = 1350;
   localparam int unsigned REPORT_LIMIT = 40;
   localparam int unsigned DRAIN_CYCLES = 8;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             present;
      logic [31:0]      length;
      logic [31:0]      magic;
      logic [31:0]      size;
      logic             crc;
      logic             ok;
   } flash_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid         = 1'b0;
   logic               req_ready;
   logic [CMD_W-1:0]   req_command       = CMD_POLL;
   logic               req_image_present = 1'b0;
   logic [31:0]        req_image_length  = '0;
   logic [31:0]        req_header_magic  = '0;
   logic [31:0]        req_header_size   = '0;
   logic               req_crc_matches   = 1'b0;
   logic               req_op_ok         = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready         = 1'b0;
   logic               rsp_accepted;
   logic [CODE_W-1:0]  rsp_phase;
   logic [CODE_W-1:0]  rsp_error_code;
   logic [CNT_W-1:0]   rsp_done_bytes;
   logic               rsp_changed;
   logic [CODE_W-1:0]  rsp_request_op;
   logic [ADDR_W-1:0]  rsp_request_address;
   logic [OFF_W-1:0]   rsp_request_offset;
   logic [NB_W-1:0]    rsp_request_bytes;

   // Sequencer shadow state
   logic [CODE_W-1:0] seq_phase;
   logic [CODE_W-1:0] seq_error;
   int unsigned       seq_cursor;
   int unsigned       seq_total;
   int unsigned       seq_done;
   logic              seq_changed;
   int unsigned       seq_blocks;

   fius_result_type expected_steps[$];
   int unsigned     result_errors   = 0;
   int unsigned     effective_items = 0;
   int unsigned     quiet_cycles    = 0;
   bit              no_idle         = 1'b0;
   bit              hold_off_req    = 1'b0;

   flash_image_update_sequencer DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_image_present   (req_image_present),
      .req_image_length    (req_image_length),
      .req_header_magic    (req_header_magic),
      .req_header_size     (req_header_size),
      .req_crc_matches     (req_crc_matches),
      .req_op_ok           (req_op_ok),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_accepted        (rsp_accepted),
      .rsp_phase           (rsp_phase),
      .rsp_error_code      (rsp_error_code),
      .rsp_done_bytes      (rsp_done_bytes),
      .rsp_changed         (rsp_changed),
      .rsp_request_op      (rsp_request_op),
      .rsp_request_address (rsp_request_address),
      .rsp_request_offset  (rsp_request_offset),
      .rsp_request_bytes   (rsp_request_bytes)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit seq_busy();
      return seq_phase >= PH_CHECK && seq_phase <= PH_VERIFY;
   endfunction

   function automatic void seq_clear();
      seq_phase   = PH_IDLE;
      seq_error   = ERR_NONE;
      seq_cursor  = 0;
      seq_total   = 0;
      seq_done    = 0;
      seq_changed = 1'b0;
      seq_blocks  = 0;
   endfunction

   function automatic void seq_fail(logic [CODE_W-1:0] code);
      seq_error = code;
      seq_phase = PH_FAIL;
   endfunction

   // Image bytes carried by the pending page request
   function automatic int unsigned page_fill();
      int unsigned left;
      left = (seq_cursor < seq_total) ? seq_total - seq_cursor : 0;
      return (left > PAGE_BYTES) ? PAGE_BYTES : left;
   endfunction

   function automatic fius_result_type predict_step(input flash_cmd_type c, output bit effect);
      fius_result_type r;
      int unsigned     amount;
      bit              acc;
      acc    = 1'b0;
      effect = 1'b0;
      case (c.command)
         CMD_BEGIN: begin
            if (!seq_busy() && c.present && c.length >= MIN_IMAGE_BYTES &&
                c.length <= MAX_IMAGE_BYTES && c.magic == IMAGE_MAGIC &&
                c.size == c.length && c.crc) begin
               seq_phase   = PH_CHECK;
               seq_error   = ERR_NONE;
               seq_done    = 0;
               seq_changed = 1'b0;
               seq_total   = c.length;
               seq_cursor  = 0;
               seq_blocks  = (c.length + BLOCK_BYTES - 1) / BLOCK_BYTES;
               acc = 1'b1;
            end
         end
         CMD_POLL: begin
            if (seq_busy()) begin
               effect = 1'b1;
               case (seq_phase)
                  PH_CHECK: begin
                     if (!c.ok) seq_fail(ERR_BLOCK);
                     else begin
                        seq_cursor++;
                        if (seq_cursor == seq_blocks) begin
                           seq_cursor = 0;
                           seq_phase  = PH_ERASE;
                        end
                     end
                  end
                  PH_ERASE: begin
                     // the erase counts as attempted whatever its outcome
                     seq_changed = 1'b1;
                     if (!c.ok) seq_fail(ERR_ERASE);
                     else begin
                        seq_cursor++;
                        if (seq_cursor == seq_blocks) begin
                           seq_cursor = 0;
                           seq_phase  = PH_WRITE;
                           seq_done   = 0;
                        end
                     end
                  end
                  PH_WRITE: begin
                     amount = page_fill();
                     if (!c.ok) seq_fail(ERR_PROGRAM);
                     else begin
                        seq_cursor += amount;
                        seq_done    = seq_cursor;
                        if (seq_cursor >= seq_total) begin
                           seq_cursor = 0;
                           seq_done   = 0;
                           seq_phase  = PH_VERIFY;
                        end
                     end
                  end
                  default: begin
                     amount = page_fill();
                     if (!c.ok) seq_fail(ERR_VERIFY);
                     else begin
                        seq_cursor += amount;
                        seq_done    = seq_cursor;
                        if (seq_cursor >= seq_total) seq_phase = PH_DONE;
                     end
                  end
               endcase
            end
         end
         CMD_CLEAR: begin
            if (!seq_busy()) begin
               seq_clear();
               acc = 1'b1;
            end
         end
         default: ;
      endcase
      effect = effect | acc;

      r            = '0;
      r.accepted   = acc;
      r.phase      = seq_phase;
      r.error_code = seq_error;
      r.done_bytes = CNT_W'(seq_done);
      r.changed    = seq_changed;
      if (seq_phase == PH_CHECK || seq_phase == PH_ERASE) begin
         r.request_op      = (seq_phase == PH_CHECK) ? OP_CHECK : OP_ERASE;
         r.request_address = ADDR_W'(FIRST_BLOCK + seq_cursor);
      end else if (seq_phase == PH_WRITE || seq_phase == PH_VERIFY) begin
         r.request_op      = (seq_phase == PH_WRITE) ? OP_PROGRAM : OP_COMPARE;
         r.request_address = ADDR_W'(FIRST_PAGE + seq_cursor / PAGE_BYTES);
         r.request_offset  = OFF_W'(seq_cursor);
         r.request_bytes   = NB_W'(page_fill());
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // Mostly back to back, sometimes a short gap, rarely a long pause
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic flash_cmd_type good_begin(int unsigned len);
      flash_cmd_type c;
      c         = '0;
      c.command = CMD_BEGIN;
      c.present = 1'b1;
      c.length  = len;
      c.magic   = IMAGE_MAGIC;
      c.size    = len;
      c.crc     = 1'b1;
      c.ok      = 1'($urandom_range(0, 1));
      return c;
   endfunction

   function automatic flash_cmd_type poll_item(bit ok);
      flash_cmd_type c;
      c         = '0;
      c.command = CMD_POLL;
      c.ok      = ok;
      c.length  = $urandom();
      c.magic   = $urandom();
      return c;
   endfunction

   function automatic flash_cmd_type clear_item();
      flash_cmd_type c;
      c         = '0;
      c.command = CMD_CLEAR;
      c.present = 1'($urandom_range(0, 1));
      c.size    = $urandom();
      return c;
   endfunction

   function automatic flash_cmd_type random_item();
      flash_cmd_type c;
      c.command = CMD_W'($urandom_range(0, 3));
      c.present = 1'($urandom_range(0, 1));
      c.length  = $urandom();
      c.magic   = $urandom();
      c.size    = $urandom();
      c.crc     = 1'($urandom_range(0, 1));
      c.ok      = 1'($urandom_range(0, 1));
      return c;
   endfunction

   // Well-formed begin with exactly one header check spoiled
   function automatic flash_cmd_type broken_begin(int unsigned len);
      flash_cmd_type c;
      c = good_begin(len);
      case ($urandom_range(0, 5))
         0: c.present = 1'b0;
         1: begin
            c.length = $urandom_range(0, MIN_IMAGE_BYTES - 1);
            c.size   = c.length;
         end
         2: begin
            c.length = MAX_IMAGE_BYTES + 1 + $urandom_range(0, 1000000);
            c.size   = c.length;
         end
         3: c.magic = c.magic ^ (32'd1 << $urandom_range(0, 31));
         4: c.size  = c.size ^ (32'd1 << $urandom_range(0, 31));
         default: c.crc = 1'b0;
      endcase
      return c;
   endfunction

   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 72) return $urandom_range(MIN_IMAGE_BYTES, 6000);
      if (r < 97) return $urandom_range(6001, 40000);
      return BLOCK_BYTES - 1 + $urandom_range(0, 2);
   endfunction

   // Offer one transaction and record its expected result once accepted
   task automatic send_item(input flash_cmd_type c);
      int unsigned     gap;
      fius_result_type r;
      bit              eff;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= c.command;
      req_image_present <= c.present;
      req_image_length  <= c.length;
      req_header_magic  <= c.magic;
      req_header_size   <= c.size;
      req_crc_matches   <= c.crc;
      req_op_ok         <= c.ok;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = predict_step(c, eff);
      expected_steps.push_back(r);
      if (eff) effective_items++;
   endtask

   // Start an update and poll it to the end; fail the poll numbered fail_at
   task automatic run_image(int unsigned len, int fail_at, int unsigned noise_pct);
      int n;
      int unsigned r;
      n = 0;
      send_item(good_begin(len));
      while (seq_busy()) begin
         r = $urandom_range(0, 99);
         if (r < noise_pct) begin
            case (r % 3)
               0: send_item(random_item());
               1: send_item(clear_item());
               default: send_item(good_begin(pick_length()));
            endcase
         end else begin
            send_item(poll_item(n != fail_at));
            n++;
         end
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_idle_commands();
      flash_cmd_type c;
      send_item(poll_item(1'b1));
      send_item(poll_item(1'b0));
      c = random_item();
      c.command = CMD_UNUSED;
      send_item(c);
      send_item(clear_item());
   endtask

   task automatic test_header_rejects();
      flash_cmd_type c;
      c = good_begin(1000);
      c.present = 1'b0;
      send_item(c);
      send_item(good_begin(MIN_IMAGE_BYTES - 1));
      send_item(good_begin(0));
      send_item(good_begin(MAX_IMAGE_BYTES + 1));
      send_item(good_begin(32'hffff_ffff));
      c = good_begin(1000);
      c.magic = ~IMAGE_MAGIC;
      send_item(c);
      c = good_begin(1000);
      c.size = 1001;
      send_item(c);
      c = good_begin(1000);
      c.crc = 1'b0;
      send_item(c);
   endtask

   task automatic test_smallest_image();
      send_item(good_begin(MIN_IMAGE_BYTES));
      // begin and clear are both refused while busy
      send_item(good_begin(4096));
      send_item(clear_item());
      repeat (4) send_item(poll_item(1'b1));
      send_item(poll_item(1'b1));
      send_item(clear_item());
   endtask

   task automatic test_failure_per_phase();
      int k;
      for (k = 0; k < 4; k++) begin
         send_item(clear_item());
         run_image(MIN_IMAGE_BYTES, k, 0);
      end
   endtask

   task automatic test_largest_image();
      send_item(clear_item());
      run_image(MAX_IMAGE_BYTES, 2 * (MAX_IMAGE_BYTES / BLOCK_BYTES) + 20, 0);
   endtask

   task automatic test_size_boundaries();
      run_image(PAGE_BYTES + 1, -1, 0);
      run_image(BLOCK_BYTES, -1, 0);
      run_image(BLOCK_BYTES + 1, -1, 0);
   endtask

   task automatic test_back_pressure();
      no_idle      = 1'b1;
      hold_off_req = 1'b1;
      run_image(30000, -1, 0);
      no_idle      = 1'b0;
   endtask

   task automatic test_random_updates();
      int unsigned r;
      int unsigned len;
      int unsigned polls;
      int          fail_at;
      while (effective_items < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            send_item(random_item());
         end else if (r < 22) begin
            send_item(broken_begin(pick_length()));
         end else begin
            if ($urandom_range(0, 2) == 0) send_item(clear_item());
            len   = pick_length();
            polls = 2 * ((len + BLOCK_BYTES - 1) / BLOCK_BYTES) +
                    2 * ((len + PAGE_BYTES - 1) / PAGE_BYTES);
            fail_at = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, polls - 1)) : -1;
            run_image(len, fail_at, 10);
         end
      end
   endtask

   // ---------------------------------------------------------------- result side

   // Take results with random stalls; honor a requested long hold-off
   initial begin : rsp_side
      int unsigned stall;
      forever begin
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   function automatic void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         if (result_errors < REPORT_LIMIT)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         result_errors++;
      end
   endfunction

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin : result_check
      fius_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_steps.size() == 0) begin
            if (result_errors < REPORT_LIMIT)
               $display("%0t: result with no expectation: expected none, actual phase %0d",
                        $time, rsp_phase);
            result_errors++;
         end else begin
            want = expected_steps.pop_front();
            check_field("accepted", want.accepted, rsp_accepted);
            check_field("phase", want.phase, rsp_phase);
            check_field("error_code", want.error_code, rsp_error_code);
            check_field("done_bytes", want.done_bytes, rsp_done_bytes);
            check_field("changed", want.changed, rsp_changed);
            check_field("request_op", want.request_op, rsp_request_op);
            check_field("request_address", want.request_address, rsp_request_address);
            check_field("request_offset", want.request_offset, rsp_request_offset);
            check_field("request_bytes", want.request_bytes, rsp_request_bytes);
         end
      end
   end

   // Stop a run that makes no progress on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("flash_image_update_sequencer verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      seq_clear();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_idle_commands();
      test_header_rejects();
      test_smallest_image();
      test_failure_per_phase();
      test_size_boundaries();
      test_back_pressure();
      test_largest_image();
      test_random_updates();
      req_valid <= 1'b0;
      while (expected_steps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (result_errors == 0) begin
         $display("flash_image_update_sequencer verification clean");
      end else begin
         $display("flash_image_update_sequencer verification failed");
      end
      $finish;
   end

endmodule
